// ===== hw/rtl/fdcps_pkg.sv =====
// Shared types and constants for the floppy controller phase sequencer.
// No dependencies; imported by every module of the block.
package fdcps_pkg;

  // Disk geometry
  localparam int unsigned SectorBytes     = 512;
  localparam int unsigned SectorsPerTrack = 18;
  localparam int unsigned DiskBytes       = 1474560;

  localparam int unsigned AddrW   = $clog2(DiskBytes);
  localparam int unsigned OffW    = $clog2(SectorBytes);
  // Sector index ((track*2 + head)*spt + sector - 1) stays below 2^15 for the
  // largest geometry (765*18 + 254).
  localparam int unsigned SecIdxW = 15;
  localparam int unsigned LinW    = SecIdxW + OffW + 1;

  // Access kinds
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Bus ports
  localparam logic [1:0] PortFifo   = 2'd0;
  localparam logic [1:0] PortStatus = 2'd1;
  localparam logic [1:0] PortDor    = 2'd2;
  localparam logic [1:0] PortCcr    = 2'd3;

  // Command nibbles
  localparam logic [3:0] CmdSense   = 4'h8;
  localparam logic [3:0] CmdSpecify = 4'h3;
  localparam logic [3:0] CmdRecal   = 4'h7;
  localparam logic [3:0] CmdRead    = 4'h6;
  localparam logic [3:0] CmdWrite   = 4'h5;

  localparam logic [7:0] StatusRqm  = 8'h80;
  localparam int unsigned DorResetBit = 2;

  localparam logic [3:0] SpecifyParams = 4'd2;
  localparam logic [3:0] XferParams    = 4'd8;
  localparam logic [2:0] ResultBytes   = 3'd7;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhCmd    = 2'd1,
    PhExec   = 2'd2,
    PhResult = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KindSense   = 3'd0,
    KindSpecify = 3'd1,
    KindRecal   = 3'd2,
    KindRead    = 3'd3,
    KindWrite   = 3'd4
  } kind_e;

  // Result of one access, as produced by the sequencer core
  typedef struct packed {
    logic [7:0] data;
    logic       irq;
    logic       bad;
    logic       from_mem;
  } result_t;

  // Disk store access request
  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/fdcps_disk_mem.sv =====
// Byte-wide disk store with a zeroing sweep after reset.
// Depends on fdcps_pkg for geometry and the request struct.
module fdcps_disk_mem
  import fdcps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_req_t   req_i,
  output logic       busy_o,
  output logic [7:0] rdata_o
);

  logic [7:0]       mem [DiskBytes];
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;
  logic [7:0]       rdata_q;

  // Advance the clearing sweep, one byte a cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(DiskBytes - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Write port: sweep first, then sector writes
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  // Registered read port, held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign busy_o  = clr_busy_q;
  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fdcps_core.sv =====
// Phase sequencer core: controller state and per-access decode.
// Depends on fdcps_pkg; drives the disk store request for the top level.
module fdcps_core
  import fdcps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       op_i,
  input  logic [1:0] port_i,
  input  logic [7:0] wdata_i,
  output result_t    result_o,
  output mem_req_t   mem_req_o
);

  phase_e          phase_q, phase_d;
  kind_e           kind_q, kind_d;
  logic [3:0]      param_q, param_d;
  logic [2:0]      rcnt_q, rcnt_d;
  logic [7:0]      track_q, track_d;
  logic [7:0]      head_q, head_d;
  logic [7:0]      sector_q, sector_d;
  logic [OffW-1:0] off_q, off_d;

  logic [SecIdxW-1:0] th, sec_idx;
  logic [LinW-1:0]    lin;
  logic               in_range;
  logic [3:0]         param_inc;
  logic [2:0]         rcnt_inc;
  logic               off_last;
  result_t            res;
  mem_req_t           req;

  // Disk address from the current track, head, sector and offset
  always_comb begin
    th       = SecIdxW'({track_q, 1'b0}) + SecIdxW'(head_q);
    sec_idx  = SecIdxW'(th * SecIdxW'(SectorsPerTrack)) + SecIdxW'(sector_q) - SecIdxW'(1);
    lin      = LinW'(LinW'(sec_idx) * LinW'(SectorBytes)) + LinW'(off_q);
    in_range = (sector_q != 8'd0) && (lin < LinW'(DiskBytes));
  end

  assign param_inc = param_q + 4'd1;
  assign rcnt_inc  = rcnt_q + 3'd1;
  assign off_last  = (off_q == OffW'(SectorBytes - 1));

  // Decode one access and work out the next state
  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    param_d  = param_q;
    rcnt_d   = rcnt_q;
    track_d  = track_q;
    head_d   = head_q;
    sector_d = sector_q;
    off_d    = off_q;
    res      = '0;
    req      = '0;
    req.addr = lin[AddrW-1:0];
    req.wdata = wdata_i;

    if (op_i == OpWrite) begin
      case (port_i)
        PortFifo: begin
          unique case (phase_q)
            PhIdle: begin
              res.bad = 1'b0;
              case (wdata_i[3:0])
                CmdSense:   kind_d = KindSense;
                CmdSpecify: kind_d = KindSpecify;
                CmdRecal:   kind_d = KindRecal;
                CmdRead:    kind_d = KindRead;
                CmdWrite:   kind_d = KindWrite;
                default:    res.bad = 1'b1;
              endcase
              if (!res.bad) begin
                param_d = 4'd0;
                rcnt_d  = 3'd0;
                phase_d = PhCmd;
              end else begin
                kind_d = kind_q;
              end
            end
            PhCmd: begin
              unique case (kind_q)
                KindSpecify: begin
                  param_d = param_inc;
                  if (param_inc >= SpecifyParams) begin
                    param_d = 4'd0;
                    phase_d = PhIdle;
                  end
                end
                KindRecal: begin
                  param_d = 4'd0;
                  phase_d = PhIdle;
                  res.irq = 1'b1;
                end
                KindRead, KindWrite: begin
                  param_d = param_inc;
                  if (param_inc == 4'd2) begin
                    track_d = wdata_i;
                  end else if (param_inc == 4'd3) begin
                    head_d = wdata_i;
                  end else if (param_inc == 4'd4) begin
                    sector_d = wdata_i;
                  end else if (param_inc >= XferParams) begin
                    param_d = 4'd0;
                    off_d   = '0;
                    phase_d = PhExec;
                    res.irq = 1'b1;
                  end
                end
                default: res.bad = 1'b1;
              endcase
            end
            PhExec: begin
              if (kind_q == KindWrite) begin
                req.we = in_range;
                off_d  = off_q + OffW'(1);
                if (off_last) begin
                  off_d   = '0;
                  phase_d = PhResult;
                end
              end else begin
                res.bad = 1'b1;
              end
            end
            PhResult: res.bad = 1'b1;
            default:  res.bad = 1'b1;
          endcase
        end
        PortDor: begin
          if (wdata_i[DorResetBit]) begin
            phase_d = PhIdle;
            res.irq = 1'b1;
          end
        end
        PortCcr: ;
        default: res.bad = 1'b1;
      endcase
    end else begin
      case (port_i)
        PortFifo: begin
          if (phase_q == PhCmd && kind_q == KindSense) begin
            param_d = param_inc;
            if (param_inc >= SpecifyParams) begin
              param_d = 4'd0;
              phase_d = PhIdle;
            end
          end else if (phase_q == PhExec && kind_q == KindRead) begin
            req.re       = in_range;
            res.from_mem = in_range;
            off_d        = off_q + OffW'(1);
            if (off_last) begin
              off_d   = '0;
              phase_d = PhResult;
            end
          end else if (phase_q == PhResult &&
                       (kind_q == KindRead || kind_q == KindWrite)) begin
            rcnt_d = rcnt_inc;
            if (rcnt_inc >= ResultBytes) begin
              rcnt_d  = 3'd0;
              phase_d = PhIdle;
            end
          end else begin
            res.bad = 1'b1;
          end
        end
        PortStatus: res.data = StatusRqm;
        default:    res.bad = 1'b1;
      endcase
    end

    // Drop every effect of a bad access
    if (res.bad) begin
      phase_d  = phase_q;
      kind_d   = kind_q;
      param_d  = param_q;
      rcnt_d   = rcnt_q;
      track_d  = track_q;
      head_d   = head_q;
      sector_d = sector_q;
      off_d    = off_q;
      res.irq  = 1'b0;
      res.data = 8'h00;
      res.from_mem = 1'b0;
      req.we   = 1'b0;
      req.re   = 1'b0;
    end

    // Nothing moves without a transfer
    if (!step_i) begin
      req.we = 1'b0;
      req.re = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      kind_q   <= KindSense;
      param_q  <= 4'd0;
      rcnt_q   <= 3'd0;
      track_q  <= 8'd0;
      head_q   <= 8'd0;
      sector_q <= 8'd0;
      off_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      param_q  <= param_d;
      rcnt_q   <= rcnt_d;
      track_q  <= track_d;
      head_q   <= head_d;
      sector_q <= sector_d;
      off_q    <= off_d;
    end
  end

  assign result_o  = res;
  assign mem_req_o = req;

endmodule

// ===== hw/rtl/floppy_controller_phase_sequencer_unit.sv =====
// Top level of the floppy controller phase sequencer.
// Depends on fdcps_pkg, fdcps_core and fdcps_disk_mem.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  access  | in_valid_i / in_ready_o | op_i, port_i, write_data_i
//  result  | out_valid_o/out_ready_i | read_data_o, irq_o, bad_access_o
//
// Each access goes from the input register to the result register, and one
// access is taken every cycle while the result channel does not stall; the
// decode in the core and the single disk store port set that rate. After
// reset the disk store is zeroed one byte a cycle, all DiskBytes (1474560)
// bytes, during which in_ready_o stays low. A stalled result holds the
// pipeline; the input register still takes one access while the result waits.
module floppy_controller_phase_sequencer_unit
  import fdcps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [1:0] port_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_o,
  output logic       bad_access_o
);

  logic       s1_valid_q;
  logic       s1_op_q;
  logic [1:0] s1_port_q;
  logic [7:0] s1_wdata_q;
  logic       out_valid_q;
  logic [7:0] data_q;
  logic       irq_q;
  logic       bad_q;
  logic       from_mem_q;

  logic       step;
  logic       busy;
  logic [7:0] mem_rdata;
  result_t    res;
  mem_req_t   mem_req;

  // Advance into the result register when it is empty or being drained
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy && (!s1_valid_q || step);

  fdcps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .op_i      (s1_op_q),
    .port_i    (s1_port_q),
    .wdata_i   (s1_wdata_q),
    .result_o  (res),
    .mem_req_o (mem_req)
  );

  fdcps_disk_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .busy_o  (busy),
    .rdata_o (mem_rdata)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the access payload on transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= op_i;
      s1_port_q  <= port_i;
      s1_wdata_q <= write_data_i;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result payload until the next step
  always_ff @(posedge clk_i) begin
    if (step) begin
      data_q     <= res.data;
      irq_q      <= res.irq;
      bad_q      <= res.bad;
      from_mem_q <= res.from_mem;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = from_mem_q ? mem_rdata : data_q;
  assign irq_o        = irq_q;
  assign bad_access_o = bad_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for floppy_controller_phase_sequencer_unit.
// Depends on fdcps_pkg; a scoreboard class tracks the controller phases and a disk image,
// and plain tasks drive bus accesses with random idle cycles and result stalls.
module testbench
  import fdcps_pkg::*;
();

  // Positions of the seek bytes among the eight transfer parameters
  localparam int unsigned TrackParam  = 2;
  localparam int unsigned HeadParam   = 3;
  localparam int unsigned SectorParam = 4;
  localparam logic [3:0]  SenseReads  = 4'd2;
  localparam logic [7:0]  LastTrack   = 8'd79;

  typedef struct packed {
    logic [7:0] data;
    logic       irq;
    logic       bad;
  } reply_t;

  typedef struct packed {
    logic [7:0] trk;
    logic [7:0] hd;
    logic [7:0] sec;
  } place_t;

  // Shadow of the controller: phase, command, seek registers and disk image
  class fdc_replies;
    phase_e     phase_q;
    kind_e      kind_q;
    logic [3:0] param_cnt;
    logic [2:0] result_cnt;
    logic [7:0] track_q;
    logic [7:0] head_q;
    logic [7:0] sector_q;
    logic [8:0] offset_q;
    bit   [7:0] disk_img [DiskBytes];
    reply_t     due_replies [$];
    int         fails;
    int         checked;
    int         irqs;
    int         rejects;
    int         sectors_done;

    function new();
      phase_q      = PhIdle;
      kind_q       = KindSense;
      param_cnt    = '0;
      result_cnt   = '0;
      track_q      = '0;
      head_q       = '0;
      sector_q     = '0;
      offset_q     = '0;
      fails        = 0;
      checked      = 0;
      irqs         = 0;
      rejects      = 0;
      sectors_done = 0;
    endfunction

    // Map track, head, sector and offset to a byte of the image; sector 0 and
    // anything past the end of the disk have no byte
    function bit locate(output int unsigned idx);
      longint unsigned lin;
      idx = 0;
      if (sector_q == 8'd0) return 1'b0;
      lin = track_q;
      lin = (lin * 2 + head_q) * SectorsPerTrack + sector_q - 1;
      lin = lin * SectorBytes + offset_q;
      if (lin >= DiskBytes) return 1'b0;
      idx = lin[31:0];
      return 1'b1;
    endfunction

    // Advance through the sector; the last byte moves on to the result phase
    function void advance_byte();
      if (offset_q == 9'(SectorBytes - 1)) begin
        offset_q = '0;
        phase_q  = PhResult;
        sectors_done++;
      end else begin
        offset_q = offset_q + 9'd1;
      end
    endfunction

    function bit fifo_write(input logic [7:0] d, output logic irq);
      int unsigned idx;
      irq = 1'b0;
      case (phase_q)
        PhIdle: begin
          case (d[3:0])
            CmdSense:   kind_q = KindSense;
            CmdSpecify: kind_q = KindSpecify;
            CmdRecal:   kind_q = KindRecal;
            CmdRead:    kind_q = KindRead;
            CmdWrite:   kind_q = KindWrite;
            default:    return 1'b0;
          endcase
          param_cnt  = '0;
          result_cnt = '0;
          phase_q    = PhCmd;
          return 1'b1;
        end
        PhCmd: begin
          if (kind_q == KindSpecify) begin
            param_cnt++;
            if (param_cnt >= SpecifyParams) begin
              param_cnt = '0;
              phase_q   = PhIdle;
            end
            return 1'b1;
          end
          if (kind_q == KindRecal) begin
            param_cnt = '0;
            phase_q   = PhIdle;
            irq       = 1'b1;
            return 1'b1;
          end
          if (kind_q == KindRead || kind_q == KindWrite) begin
            param_cnt++;
            if (param_cnt == TrackParam) track_q = d;
            else if (param_cnt == HeadParam) head_q = d;
            else if (param_cnt == SectorParam) sector_q = d;
            else if (param_cnt >= XferParams) begin
              param_cnt = '0;
              offset_q  = '0;
              phase_q   = PhExec;
              irq       = 1'b1;
            end
            return 1'b1;
          end
          return 1'b0;
        end
        PhExec: begin
          if (kind_q != KindWrite) return 1'b0;
          if (locate(idx)) disk_img[idx] = d;
          advance_byte();
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function bit fifo_read(output logic [7:0] data);
      int unsigned idx;
      data = '0;
      if (phase_q == PhCmd && kind_q == KindSense) begin
        param_cnt++;
        if (param_cnt >= SenseReads) begin
          param_cnt = '0;
          phase_q   = PhIdle;
        end
        return 1'b1;
      end
      if (phase_q == PhExec && kind_q == KindRead) begin
        if (locate(idx)) data = disk_img[idx];
        advance_byte();
        return 1'b1;
      end
      if (phase_q == PhResult && (kind_q == KindRead || kind_q == KindWrite)) begin
        result_cnt++;
        if (result_cnt >= ResultBytes) begin
          result_cnt = '0;
          phase_q    = PhIdle;
        end
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Work out the reply to one accepted access and queue it
    function void note_access(input logic op, input logic [1:0] port, input logic [7:0] d);
      reply_t r;
      logic   ok;
      r  = '0;
      ok = 1'b1;
      if (op == OpWrite) begin
        case (port)
          PortFifo: ok = fifo_write(d, r.irq);
          PortDor: begin
            if (d[DorResetBit]) begin
              phase_q = PhIdle;
              r.irq   = 1'b1;
            end
          end
          PortCcr: ok = 1'b1;
          default: ok = 1'b0;
        endcase
      end else begin
        case (port)
          PortFifo:   ok = fifo_read(r.data);
          PortStatus: r.data = StatusRqm;
          default:    ok = 1'b0;
        endcase
      end
      if (!ok) begin
        r     = '0;
        r.bad = 1'b1;
        rejects++;
      end
      if (r.irq) irqs++;
      due_replies.push_back(r);
    endfunction

    task report_miss(input string msg);
      $display("MISMATCH at reply %0d: %s", checked, msg);
      fails++;
    endtask

    // Compare one transfer on the result channel with the oldest reply due
    task check_reply(input logic [7:0] data, input logic irq, input logic bad);
      reply_t want;
      if (due_replies.size() == 0) begin
        report_miss($sformatf("unexpected result data %02h irq %b bad %b", data, irq, bad));
        return;
      end
      want = due_replies.pop_front();
      if (data !== want.data)
        report_miss($sformatf("read_data %02h, expected %02h", data, want.data));
      if (irq !== want.irq)
        report_miss($sformatf("irq %b, expected %b", irq, want.irq));
      if (bad !== want.bad)
        report_miss($sformatf("bad_access %b, expected %b", bad, want.bad));
      checked++;
    endtask
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic       op_i         = OpRead;
  logic [1:0] port_i       = PortStatus;
  logic [7:0] write_data_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] read_data_o;
  logic       irq_o;
  logic       bad_access_o;

  fdc_replies  replies;
  int unsigned sent_cnt = 0;
  bit          calm     = 1'b0;
  place_t      spots [4];

  floppy_controller_phase_sequencer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .port_i       (port_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .irq_o        (irq_o),
    .bad_access_o (bad_access_o)
  );

  always #4 clk_i = ~clk_i;

  // Check each result transfer, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) replies.check_reply(read_data_o, irq_o, bad_access_o);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 23);
    end
  end

  // Offer one access, idling at random first, and hold it until the transfer
  task automatic send_access(input logic op, input logic [1:0] port, input logic [7:0] d);
    if (!calm) begin
      while ($urandom_range(0, 99) < 23) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    port_i       <= port;
    write_data_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    replies.note_access(op, port, d);
    sent_cnt++;
  endtask

  // Accesses that leave the phase alone, accepted or rejected
  task automatic stray_access();
    logic [7:0] d;
    d = 8'($urandom);
    case ($urandom_range(0, 4))
      0: send_access(OpRead, PortStatus, d);
      1: send_access(OpWrite, PortCcr, d);
      2: begin
        d[DorResetBit] = 1'b0;
        send_access(OpWrite, PortDor, d);
      end
      3: send_access(OpWrite, PortStatus, d);
      default: send_access(OpRead, $urandom_range(0, 1) ? PortDor : PortCcr, d);
    endcase
  endtask

  task automatic dor_reset();
    logic [7:0] d;
    d = 8'($urandom);
    d[DorResetBit] = 1'b1;
    send_access(OpWrite, PortDor, d);
  endtask

  task automatic issue_cmd(input logic [3:0] nib);
    send_access(OpWrite, PortFifo, {4'($urandom_range(0, 15)), nib});
  endtask

  // Data port accesses with an occasional stray access mixed in
  task automatic pump_bytes(input logic op, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 6) stray_access();
      send_access(op, PortFifo, 8'($urandom));
    end
  endtask

  task automatic seek_to(input place_t p);
    logic [7:0] b;
    for (int unsigned n = 1; n <= XferParams; n++) begin
      if ($urandom_range(0, 99) < 4) stray_access();
      if (n == TrackParam) b = p.trk;
      else if (n == HeadParam) b = p.hd;
      else if (n == SectorParam) b = p.sec;
      else b = 8'($urandom);
      send_access(OpWrite, PortFifo, b);
    end
  endtask

  // Mostly real sectors; some sector 0, some past the end of the disk
  function automatic place_t any_place();
    place_t      p;
    int unsigned roll;
    roll  = $urandom_range(0, 99);
    p.trk = 8'($urandom_range(0, LastTrack));
    p.hd  = 8'($urandom_range(0, 1));
    p.sec = 8'($urandom_range(1, SectorsPerTrack));
    if (roll < 12) p.sec = 8'd0;
    else if (roll < 20) p.trk = 8'($urandom_range(LastTrack + 1, 255));
    else if (roll < 26) p.hd = 8'($urandom_range(2, 255));
    else if (roll < 32) begin
      p.trk = LastTrack;
      p.hd  = 8'd1;
      p.sec = 8'($urandom_range(SectorsPerTrack + 1, 255));
    end
    return p;
  endfunction

  // Hold off the next access until every reply has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (replies.due_replies.size() != 0) @(posedge clk_i);
  endtask

  // Random mix of short command sequences, aborted transfers and noise
  task automatic run_mix(input int unsigned upto);
    int unsigned roll;
    place_t      p;
    logic [3:0]  nib;
    while (sent_cnt < upto) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        issue_cmd(CmdSpecify);
        pump_bytes(OpWrite, SpecifyParams);
      end else if (roll < 16) begin
        issue_cmd(CmdRecal);
        pump_bytes(OpWrite, 1);
      end else if (roll < 24) begin
        issue_cmd(CmdSense);
        pump_bytes(OpRead, SenseReads);
      end else if (roll < 48) begin
        p = $urandom_range(0, 1) ? any_place() : spots[$urandom_range(0, 3)];
        spots[$urandom_range(0, 3)] = p;
        issue_cmd(CmdWrite);
        seek_to(p);
        pump_bytes(OpWrite, $urandom_range(1, 24));
        dor_reset();
      end else if (roll < 72) begin
        p = ($urandom_range(0, 3) == 0) ? any_place() : spots[$urandom_range(0, 3)];
        issue_cmd(CmdRead);
        seek_to(p);
        pump_bytes(OpRead, $urandom_range(1, 32));
        dor_reset();
      end else if (roll < 80) begin
        do nib = 4'($urandom_range(0, 15));
        while (nib == CmdSense || nib == CmdSpecify || nib == CmdRecal ||
               nib == CmdRead || nib == CmdWrite);
        issue_cmd(nib);
      end else if (roll < 88) begin
        // drop a transfer command partway through its parameters
        issue_cmd($urandom_range(0, 1) ? CmdRead : CmdWrite);
        pump_bytes(OpWrite, $urandom_range(0, XferParams - 1));
        dor_reset();
      end else if (roll < 94) begin
        stray_access();
      end else begin
        repeat ($urandom_range(1, 4)) send_access(1'($urandom), 2'($urandom), 8'($urandom));
        dor_reset();
      end
    end
  endtask

  initial begin
    place_t last;
    replies = new();
    last    = '{trk: LastTrack, hd: 8'd1, sec: 8'(SectorsPerTrack)};
    foreach (spots[i]) spots[i] = last;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every port and direction, command bytes at the extremes
    send_access(OpRead, PortStatus, 8'h00);
    send_access(OpWrite, PortStatus, 8'hFF);
    send_access(OpRead, PortDor, 8'hFF);
    send_access(OpRead, PortCcr, 8'h00);
    send_access(OpRead, PortFifo, 8'hFF);
    send_access(OpWrite, PortCcr, 8'hFF);
    send_access(OpWrite, PortDor, 8'hFB);
    send_access(OpWrite, PortDor, 8'h04);
    send_access(OpWrite, PortFifo, 8'h00);
    send_access(OpWrite, PortFifo, 8'hFF);
    send_access(OpWrite, PortFifo, {4'hF, CmdSpecify});
    send_access(OpWrite, PortFifo, 8'h00);
    send_access(OpWrite, PortFifo, 8'hFF);
    send_access(OpWrite, PortFifo, {4'h0, CmdRecal});
    send_access(OpWrite, PortFifo, 8'hFF);
    send_access(OpWrite, PortFifo, {4'hA, CmdSense});
    send_access(OpWrite, PortFifo, 8'h55);
    send_access(OpRead, PortFifo, 8'h00);
    send_access(OpRead, PortFifo, 8'hFF);
    send_access(OpWrite, PortFifo, {4'h0, CmdWrite});
    send_access(OpRead, PortFifo, 8'h00);
    send_access(OpRead, PortStatus, 8'hAA);
    send_access(OpWrite, PortFifo, 8'hFF);
    send_access(OpWrite, PortDor, 8'hFF);

    // Fill the last sector of the disk, then run through its result bytes
    issue_cmd(CmdWrite);
    seek_to(last);
    pump_bytes(OpWrite, SectorBytes);
    pump_bytes(OpRead, ResultBytes);

    // Let every outstanding reply come back before going on
    drain_results();

    run_mix(650);

    // Read half the sector back with both sides running flat out, then drop it
    calm = 1'b1;
    issue_cmd(CmdRead);
    seek_to(last);
    pump_bytes(OpRead, SectorBytes / 2);
    dor_reset();
    calm = 1'b0;

    run_mix(950);

    in_valid_i <= 1'b0;
    while (replies.due_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d bus accesses and %0d checked replies, %0d with an interrupt,",
             sent_cnt, replies.checked, replies.irqs);
    $display("%0d rejected accesses and %0d complete sector transfers.",
             replies.rejects, replies.sectors_done);
    if (replies.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run; the timeout also has to cover the disk clear after reset
  initial begin
    #48000000;
    $display("Timeout: replies still outstanding");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fdcps_pkg.sv
hw/rtl/fdcps_disk_mem.sv
hw/rtl/fdcps_core.sv
hw/rtl/floppy_controller_phase_sequencer_unit.sv
test/testbench.sv
